// File: rtl/gauss_elimination_solver_defines.svh
// Assertion macros for the Gaussian elimination solver.
`ifndef GAUSS_ELIMINATION_SOLVER_DEFINES_SVH
`define GAUSS_ELIMINATION_SOLVER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GES_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ges assertion failed");
`define GES_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ges assertion failed");
`else
`define GES_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GES_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/ges_pkg.sv
// Shared constants and types of the Gaussian elimination solver.
`timescale 1ns / 1ps
`default_nettype none
package ges_pkg;
    localparam int N         = 4;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 4;
    localparam int COLS      = N + 1;
    localparam int CELLS     = N * COLS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int ROW_W     = $clog2(N);
    localparam int COL_W     = $clog2(COLS + 1);
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    // one classified coefficient on its way to the back end
    typedef struct packed {
        logic signed [DATA_W-1:0] coef;
        logic [ADDR_W-1:0]        addr;
        logic                     run_end;
    } ges_entry_t;

    // request to the shared divider
    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] num;
        logic signed [DATA_W-1:0] den;
    } ges_div_req_t;

    // divider answer
    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] quot;
    } ges_div_rsp_t;
endpackage
`default_nettype wire

// File: rtl/ges_front.sv
// Front end: takes coefficients, tags each with its store address and run end.
`timescale 1ns / 1ps
`default_nettype none
module ges_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [ges_pkg::DATA_W-1:0] in_coef,
    output logic                                q_push,
    output ges_pkg::ges_entry_t                 q_entry,
    input  wire logic                           q_full
);
    logic [ges_pkg::ADDR_W-1:0] load_count_reg, load_count_next;
    logic                       end_of_run;

    assign end_of_run = (load_count_reg == ges_pkg::ADDR_W'(ges_pkg::CELLS - 1));
    assign in_ready   = !q_full;
    assign q_push     = in_valid && !q_full;

    always_comb begin
        q_entry.coef    = in_coef;
        q_entry.addr    = load_count_reg;
        q_entry.run_end = end_of_run;
        load_count_next = load_count_reg;
        if (q_push) begin
            load_count_next = end_of_run ? '0 : load_count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_count_reg <= '0;
        end else begin
            load_count_reg <= load_count_next;
        end
    end
endmodule
`default_nettype wire

// File: rtl/ges_queue.sv
// Short FIFO between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module ges_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire ges_pkg::ges_entry_t push_entry,
    output logic                     full,
    input  wire logic                pop,
    output ges_pkg::ges_entry_t      pop_entry,
    output logic                     not_empty
);
    ges_pkg::ges_entry_t            slot_reg [ges_pkg::Q_DEPTH];
    logic [ges_pkg::Q_PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [ges_pkg::Q_CNT_W-1:0]    count_reg;
    logic                           do_push, do_pop;

    assign full      = (count_reg == ges_pkg::Q_CNT_W'(ges_pkg::Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == ges_pkg::Q_PTR_W'(ges_pkg::Q_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == ges_pkg::Q_PTR_W'(ges_pkg::Q_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + ges_pkg::Q_CNT_W'(do_push) - ges_pkg::Q_CNT_W'(do_pop);
        end
    end
endmodule
`default_nettype wire

// File: rtl/ges_div.sv
// Bit-serial fixed-point divider, (a << FRAC_BITS) / b, truncated and saturated.
`timescale 1ns / 1ps
`default_nettype none
module ges_div (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ges_pkg::ges_div_req_t req,
    output ges_pkg::ges_div_rsp_t      rsp
);
    localparam int NUM_W = ges_pkg::DATA_W + ges_pkg::FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]          quo_reg;
    logic [ges_pkg::DATA_W-1:0] den_reg, rem_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      neg_reg, done_reg;
    logic [ges_pkg::DATA_W-1:0] a_mag, b_mag;
    logic [ges_pkg::DATA_W:0]   rem_sh, rem_diff;
    logic                      fits;

    assign a_mag    = req.num[ges_pkg::DATA_W-1] ? ~req.num + 1'b1 : req.num;
    assign b_mag    = req.den[ges_pkg::DATA_W-1] ? ~req.den + 1'b1 : req.den;
    assign rem_sh   = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign fits     = !rem_diff[ges_pkg::DATA_W];

    always_comb begin
        rsp.done = done_reg;
        if (neg_reg) begin
            if (quo_reg > NUM_W'(64'h8000_0000)) begin
                rsp.quot = {1'b1, {(ges_pkg::DATA_W-1){1'b0}}};
            end else begin
                rsp.quot = ges_pkg::DATA_W'(~quo_reg + 1'b1);
            end
        end else begin
            if (quo_reg > NUM_W'(64'h7FFF_FFFF)) begin
                rsp.quot = {1'b0, {(ges_pkg::DATA_W-1){1'b1}}};
            end else begin
                rsp.quot = ges_pkg::DATA_W'(quo_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= {a_mag, {ges_pkg::FRAC_BITS{1'b0}}};
            den_reg <= b_mag;
            rem_reg <= '0;
            neg_reg <= req.num[ges_pkg::DATA_W-1] ^ req.den[ges_pkg::DATA_W-1];
        end else if (cnt_reg != '0) begin
            rem_reg <= fits ? rem_diff[ges_pkg::DATA_W-1:0] : rem_sh[ges_pkg::DATA_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (req.start) begin
                cnt_reg <= CNT_W'(NUM_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/ges_back.sv
// Back end: matrix store, elimination sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
module ges_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_valid,
    input  wire ges_pkg::ges_entry_t   q_entry,
    output logic                       q_pop,
    output ges_pkg::ges_div_req_t      div_req,
    input  wire ges_pkg::ges_div_rsp_t div_rsp,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [ges_pkg::DATA_W-1:0] out_solution,
    output logic [ges_pkg::IDX_W-1:0]  out_index,
    output logic                       out_last,
    output logic                       out_singular
);
    localparam int DW = ges_pkg::DATA_W;
    localparam int CW = ges_pkg::COL_W;
    localparam int AW = ges_pkg::ADDR_W;
    localparam int RW = ges_pkg::ROW_W;
    localparam logic [CW-1:0] LAST_ROW = CW'(ges_pkg::N - 1);
    localparam logic [CW-1:0] RHS_COL  = CW'(ges_pkg::N);
    localparam logic signed [DW-1:0] Q_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] Q_MIN = {1'b1, {(DW-1){1'b0}}};

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_PIV_RD   = 5'd1;
    localparam logic [4:0] S_PIV_CHK  = 5'd2;
    localparam logic [4:0] S_PIV_SWAP = 5'd3;
    localparam logic [4:0] S_EL_RD    = 5'd4;
    localparam logic [4:0] S_EL_DIV   = 5'd5;
    localparam logic [4:0] S_EL_DWAIT = 5'd6;
    localparam logic [4:0] S_EL_RX    = 5'd7;
    localparam logic [4:0] S_EL_RY    = 5'd8;
    localparam logic [4:0] S_EL_MUL   = 5'd9;
    localparam logic [4:0] S_EL_WR    = 5'd10;
    localparam logic [4:0] S_BS_RR    = 5'd11;
    localparam logic [4:0] S_BS_RL    = 5'd12;
    localparam logic [4:0] S_BS_SRD   = 5'd13;
    localparam logic [4:0] S_BS_SUB   = 5'd14;
    localparam logic [4:0] S_BS_DRD   = 5'd15;
    localparam logic [4:0] S_BS_DCHK  = 5'd16;
    localparam logic [4:0] S_BS_DWAIT = 5'd17;
    localparam logic [4:0] S_BS_MRD   = 5'd18;
    localparam logic [4:0] S_BS_MUL   = 5'd19;
    localparam logic [4:0] S_BS_MWR   = 5'd20;
    localparam logic [4:0] S_OUT_RD   = 5'd21;
    localparam logic [4:0] S_OUT_WAIT = 5'd22;

    function automatic logic signed [DW-1:0] sat_wide(input logic signed [DW:0] v);
        if (v > (DW+1)'(Q_MAX)) begin
            return Q_MAX;
        end else if (v < (DW+1)'(Q_MIN)) begin
            return Q_MIN;
        end
        return DW'(v);
    endfunction

    // product shifted down with floor rounding, then saturated
    function automatic logic signed [DW-1:0] mul_sat(input logic signed [2*DW-1:0] p);
        logic signed [2*DW-1:0] s;
        s = p >>> ges_pkg::FRAC_BITS;
        if (s > (2*DW)'(Q_MAX)) begin
            return Q_MAX;
        end else if (s < (2*DW)'(Q_MIN)) begin
            return Q_MIN;
        end
        return DW'(s);
    endfunction

    logic signed [DW-1:0]   mem [ges_pkg::CELLS];
    logic signed [DW-1:0]   rd_data_reg;
    logic [RW-1:0]          row_map_reg [ges_pkg::N];
    logic [4:0]             state_reg;
    logic [CW-1:0]          c_reg, i_reg, j_reg, best_reg;
    logic signed [DW-1:0]   best_val_reg, pivot_reg, coef_reg, x_reg, y_reg, r_reg;
    logic signed [2*DW-1:0] prod_reg;
    logic                   singular_reg;
    logic                   rd_en, wr_en;
    logic [CW-1:0]          rd_row, rd_col, wr_row, wr_col;
    logic [AW-1:0]          rd_addr, wr_addr;
    logic signed [DW-1:0]   wr_data;
    logic signed [DW-1:0]   mul_a, mul_b;
    logic [DW:0]            abs_best, abs_new;
    logic                   out_free;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] phys, input logic [CW-1:0] col);
        return AW'(phys) * AW'(ges_pkg::COLS) + AW'(col);
    endfunction

    assign out_free = !out_valid || out_ready;
    assign abs_best = best_val_reg[DW-1] ? -(DW+1)'(best_val_reg) : (DW+1)'(best_val_reg);
    assign abs_new  = rd_data_reg[DW-1] ? -(DW+1)'(rd_data_reg) : (DW+1)'(rd_data_reg);
    assign mul_a    = (state_reg == S_EL_MUL) ? x_reg : rd_data_reg;
    assign mul_b    = (state_reg == S_EL_MUL) ? coef_reg : r_reg;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;

    // read port address select
    always_comb begin
        rd_en  = 1'b1;
        rd_row = i_reg;
        rd_col = c_reg;
        case (state_reg)
            S_PIV_RD, S_EL_RD, S_BS_MRD: begin
                rd_row = i_reg;
                rd_col = c_reg;
            end
            S_EL_RX: begin
                rd_row = c_reg;
                rd_col = j_reg;
            end
            S_EL_RY: begin
                rd_row = i_reg;
                rd_col = j_reg;
            end
            S_BS_RR: begin
                rd_row = c_reg;
                rd_col = RHS_COL;
            end
            S_BS_SRD: begin
                rd_row = c_reg;
                rd_col = i_reg;
            end
            S_BS_DRD: begin
                rd_row = c_reg;
                rd_col = c_reg;
            end
            S_OUT_RD: begin
                rd_row = i_reg;
                rd_col = RHS_COL;
            end
            default: rd_en = 1'b0;
        endcase
        rd_addr = cell_addr(row_map_reg[rd_row[RW-1:0]], rd_col);
    end

    // write port select
    always_comb begin
        wr_en   = 1'b0;
        wr_row  = i_reg;
        wr_col  = j_reg;
        wr_data = sat_wide((DW+1)'(y_reg) + (DW+1)'(mul_sat(prod_reg)));
        case (state_reg)
            S_EL_WR: wr_en = 1'b1;
            S_BS_DWAIT: begin
                wr_en   = div_rsp.done;
                wr_row  = c_reg;
                wr_col  = RHS_COL;
                wr_data = div_rsp.quot;
            end
            S_BS_MWR: begin
                wr_en   = 1'b1;
                wr_col  = c_reg;
                wr_data = mul_sat(prod_reg);
            end
            default: wr_en = 1'b0;
        endcase
        wr_addr = cell_addr(row_map_reg[wr_row[RW-1:0]], wr_col);
        if (q_pop) begin
            wr_en   = 1'b1;
            wr_addr = q_entry.addr;
            wr_data = q_entry.coef;
        end
    end

    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = rd_data_reg;
        div_req.den   = pivot_reg;
        if (state_reg == S_EL_DIV) begin
            div_req.start = 1'b1;
        end else if (state_reg == S_BS_DCHK && rd_data_reg != '0) begin
            div_req.start = 1'b1;
            div_req.num   = r_reg;
            div_req.den   = rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_PIV_CHK: begin
                if (i_reg == c_reg || abs_best < abs_new) begin
                    best_val_reg <= rd_data_reg;
                end
            end
            S_PIV_SWAP: pivot_reg <= best_val_reg;
            S_EL_DWAIT: coef_reg <= (div_rsp.quot == Q_MIN) ? Q_MAX : -div_rsp.quot;
            S_EL_RY:    x_reg <= rd_data_reg;
            S_EL_MUL: begin
                prod_reg <= mul_a * mul_b;
                y_reg    <= rd_data_reg;
            end
            S_BS_MUL:   prod_reg <= mul_a * mul_b;
            S_BS_RL:    r_reg <= rd_data_reg;
            S_BS_SUB:   r_reg <= sat_wide((DW+1)'(r_reg) - (DW+1)'(rd_data_reg));
            S_BS_DWAIT: begin
                if (div_rsp.done) begin
                    r_reg <= div_rsp.quot;
                end
            end
            default: ;
        endcase
        if (state_reg == S_OUT_WAIT && out_free) begin
            out_solution <= singular_reg ? '0 : rd_data_reg;
            out_index    <= ges_pkg::IDX_W'(i_reg);
            out_last     <= (i_reg == LAST_ROW);
            out_singular <= singular_reg;
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            singular_reg <= 1'b0;
            out_valid    <= 1'b0;
            c_reg        <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            best_reg     <= '0;
            for (int r = 0; r < ges_pkg::N; r++) begin
                row_map_reg[r] <= RW'(r);
            end
        end else begin
            // result register: load when free, empty on acceptance
            if (state_reg == S_OUT_WAIT && out_free) begin
                out_valid <= 1'b1;
            end else if (out_ready) begin
                out_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid && q_entry.run_end) begin
                        for (int r = 0; r < ges_pkg::N; r++) begin
                            row_map_reg[r] <= RW'(r);
                        end
                        singular_reg <= 1'b0;
                        c_reg        <= '0;
                        i_reg        <= '0;
                        state_reg    <= S_PIV_RD;
                    end
                end
                S_PIV_RD: state_reg <= S_PIV_CHK;
                S_PIV_CHK: begin
                    if (i_reg == c_reg || abs_best < abs_new) begin
                        best_reg <= i_reg;
                    end
                    if (i_reg == LAST_ROW) begin
                        state_reg <= S_PIV_SWAP;
                    end else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_PIV_RD;
                    end
                end
                S_PIV_SWAP: begin
                    if (best_reg != c_reg) begin
                        row_map_reg[best_reg[RW-1:0]] <= row_map_reg[c_reg[RW-1:0]];
                        row_map_reg[c_reg[RW-1:0]]    <= row_map_reg[best_reg[RW-1:0]];
                    end
                    if (best_val_reg == '0) begin
                        singular_reg <= 1'b1;
                        i_reg        <= '0;
                        state_reg    <= S_OUT_RD;
                    end else begin
                        i_reg     <= c_reg + 1'b1;
                        state_reg <= S_EL_RD;
                    end
                end
                S_EL_RD:  state_reg <= S_EL_DIV;
                S_EL_DIV: state_reg <= S_EL_DWAIT;
                S_EL_DWAIT: begin
                    if (div_rsp.done) begin
                        j_reg     <= c_reg;
                        state_reg <= S_EL_RX;
                    end
                end
                S_EL_RX:  state_reg <= S_EL_RY;
                S_EL_RY:  state_reg <= S_EL_MUL;
                S_EL_MUL: state_reg <= S_EL_WR;
                S_EL_WR: begin
                    if (j_reg != RHS_COL) begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_EL_RX;
                    end else if (i_reg != LAST_ROW) begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_EL_RD;
                    end else if (c_reg + 1'b1 == LAST_ROW) begin
                        c_reg     <= LAST_ROW;
                        state_reg <= S_BS_RR;
                    end else begin
                        c_reg     <= c_reg + 1'b1;
                        i_reg     <= c_reg + 1'b1;
                        state_reg <= S_PIV_RD;
                    end
                end
                S_BS_RR: state_reg <= S_BS_RL;
                S_BS_RL: begin
                    i_reg     <= LAST_ROW;
                    state_reg <= (c_reg == LAST_ROW) ? S_BS_DRD : S_BS_SRD;
                end
                S_BS_SRD: state_reg <= S_BS_SUB;
                S_BS_SUB: begin
                    if (i_reg == c_reg + 1'b1) begin
                        state_reg <= S_BS_DRD;
                    end else begin
                        i_reg     <= i_reg - 1'b1;
                        state_reg <= S_BS_SRD;
                    end
                end
                S_BS_DRD: state_reg <= S_BS_DCHK;
                S_BS_DCHK: begin
                    if (rd_data_reg == '0) begin
                        singular_reg <= 1'b1;
                        i_reg        <= '0;
                        state_reg    <= S_OUT_RD;
                    end else begin
                        state_reg <= S_BS_DWAIT;
                    end
                end
                S_BS_DWAIT: begin
                    if (div_rsp.done) begin
                        i_reg     <= '0;
                        state_reg <= (c_reg == '0) ? S_OUT_RD : S_BS_MRD;
                    end
                end
                S_BS_MRD: state_reg <= S_BS_MUL;
                S_BS_MUL: state_reg <= S_BS_MWR;
                S_BS_MWR: begin
                    if (i_reg + 1'b1 == c_reg) begin
                        c_reg     <= c_reg - 1'b1;
                        state_reg <= S_BS_RR;
                    end else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_BS_MRD;
                    end
                end
                S_OUT_RD: state_reg <= S_OUT_WAIT;
                S_OUT_WAIT: begin
                    if (out_free) begin
                        if (i_reg == LAST_ROW) begin
                            state_reg <= S_IDLE;
                        end else begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/gauss_elimination_solver.sv
// Top level of the Gaussian elimination solver with partial pivoting.
// Usage:
//  - s_ channel: one transaction per augmented-matrix coefficient, row-major,
//    N rows of N+1 signed Q16.16 words, N*(N+1) transactions per run.
//  - m_ channel: after the last coefficient, N transactions carry the unknowns
//    in order; m_tlast marks unknown N-1, m_tuser flags a zero pivot, in which
//    case every solution word is zero.
//  - Loading takes one coefficient per cycle while the queue has room. The
//    solve runs on a single-port store and a bit-serial divider: N*(N-1)/2 + N
//    divides plus multiply-accumulates (read pivot row, read target, multiply,
//    write back), then each unknown is read from the store and sent out.
//  - A 2-entry queue sits between the intake and the solver, so the next run's
//    first coefficients are taken while the solver is still busy.
//  - If m_tready is low while m_tvalid is high, the result register holds and the solver waits.
//  - Reset (aresetn low, synchronous) empties the queue, clears the load count,
//    restores the row order and drops m_tvalid. The store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "gauss_elimination_solver_defines.svh"
module gauss_elimination_solver (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] coefficient
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] solution, [35:32] unknown_index, zero pad
    output logic             m_tlast,
    output logic [0:0]       m_tuser    // [0] singular
);
    logic                  q_push, q_full, q_pop, q_not_empty;
    ges_pkg::ges_entry_t   push_entry, pop_entry;
    ges_pkg::ges_div_req_t div_req;
    ges_pkg::ges_div_rsp_t div_rsp;
    logic signed [ges_pkg::DATA_W-1:0] solution;
    logic [ges_pkg::IDX_W-1:0]         unknown_index;
    logic                              singular;

    // intake: tags each coefficient with its store slot
    ges_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_coef  (s_tdata),
        .q_push   (q_push),
        .q_entry  (push_entry),
        .q_full   (q_full)
    );

    ges_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .not_empty  (q_not_empty)
    );

    // solver sequencer plus result register
    ges_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_not_empty),
        .q_entry      (pop_entry),
        .q_pop        (q_pop),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_solution (solution),
        .out_index    (unknown_index),
        .out_last     (m_tlast),
        .out_singular (singular)
    );

    ges_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign m_tdata = {4'b0000, unknown_index, solution};
    assign m_tuser = singular;

    // a singular run never reports a nonzero solution
    `GES_ASSERT_IMP(a_singular_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[31:0] == '0)
    // end of run only on the last unknown
    `GES_ASSERT_IMP(a_last_index, aclk, aresetn, m_tvalid && m_tlast,
        m_tdata[35:32] == ges_pkg::IDX_W'(ges_pkg::N - 1))
    // a new run needs a full load, so the result register empties after the last
    `GES_ASSERT_NXT(a_gap_after_last, aclk, aresetn, m_tvalid && m_tready && m_tlast, !m_tvalid)
endmodule
`default_nettype wire
